@@ hw/rtl/ptld_pkg.sv @@
// ----------------------------------------------------------------------------
// ptld_pkg
// Shared constants, register indexes and sequencer states of the torque
// limited PID duty block.
// ----------------------------------------------------------------------------
package ptld_pkg;

    // Default sizing of the loop state
    localparam int POSITION_BITS  = 16;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int INTEGRAL_BITS  = 48;

    // Fixed field widths
    localparam int GAIN_W     = 24;
    localparam int TARGET_W   = 16;
    localparam int TORQUE_W   = 16;
    localparam int SPEED_W    = 16;
    localparam int TICK_W     = 16;
    localparam int DUTY_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int CHUNK_W    = 16;
    localparam int TQ_W       = 64;
    localparam int LIM_W      = 32;
    localparam int QUOT_BITS  = 15;
    localparam int TERM_MAX_EXP = 60;

    localparam logic [DUTY_W-1:0] DUTY_FULL = 16'h7FFF;

    // Command codes
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P     = 3'd0,
        CFG_GAIN_I     = 3'd1,
        CFG_GAIN_D     = 3'd2,
        CFG_TARGET     = 3'd3,
        CFG_MAX_TORQUE = 3'd4,
        CFG_MAX_SPEED  = 3'd5
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_STEP_MUL,
        ST_INTEG,
        ST_P_MUL,
        ST_I_LOAD,
        ST_I_MUL,
        ST_D_LOAD,
        ST_D_MUL,
        ST_D_START,
        ST_D_WAIT,
        ST_L_LOAD,
        ST_L_MUL,
        ST_L_START,
        ST_L_WAIT,
        ST_RATIO,
        ST_Q_WAIT,
        ST_DONE
    } seq_state_t;

endpackage

@@ hw/rtl/ptld_if.sv @@
// ----------------------------------------------------------------------------
// ptld channel interfaces
// Valid/ready channels for command requests and duty results.
// ----------------------------------------------------------------------------
interface ptld_cmd_if #(
    parameter int POSITION_BITS = ptld_pkg::POSITION_BITS
);
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic signed [POSITION_BITS-1:0] position;
    logic signed [ptld_pkg::SPEED_W-1:0] motor_speed;
    logic        [ptld_pkg::TICK_W-1:0]  elapsed_ticks;

    modport source (output valid, command, position, motor_speed, elapsed_ticks,
                    input ready);
    modport sink   (input valid, command, position, motor_speed, elapsed_ticks,
                    output ready);
endinterface

interface ptld_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [ptld_pkg::DUTY_W-1:0] duty;
    logic                               clamped;
    logic                               no_headroom;
    logic                               zero_interval;

    modport source (output valid, duty, clamped, no_headroom, zero_interval,
                    input ready);
    modport sink   (input valid, duty, clamped, no_headroom, zero_interval,
                    output ready);
endinterface

@@ hw/rtl/pid_torque_limited_duty.sv @@
// ----------------------------------------------------------------------------
// pid_torque_limited_duty
// PID position loop whose torque is scaled by a speed-derated torque limit
// into a signed Q1.15 PWM duty.
// ----------------------------------------------------------------------------
// One request is worked on at a time and cmd.ready is low until its result has
// been taken. A start request latches the position and goes straight to the
// result. An update request makes five short passes through a shared 24x16
// multiplier (three 16-bit chunks each) and up to three passes through a
// one-bit-per-cycle divider, of POSITION_BITS+24 steps for the derivative,
// 48 steps for the torque limit and 15 steps for the duty. With a zero tick
// count the derivative division is skipped, and the duty division is skipped
// when the limit is zero or the torque reaches full scale. Gains are Q12.12; the
// integral saturates at its signed INTEGRAL_BITS bounds. Write configuration
// only while no request is outstanding.
// ----------------------------------------------------------------------------
module pid_torque_limited_duty #(
    parameter int POSITION_BITS  = ptld_pkg::POSITION_BITS,
    parameter int GAIN_FRAC_BITS = ptld_pkg::GAIN_FRAC_BITS,
    parameter int INTEGRAL_BITS  = ptld_pkg::INTEGRAL_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ptld_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ptld_pkg::CFG_DATA_W-1:0]   cfg_data,
    ptld_cmd_if.sink                          cmd,
    ptld_res_if.source                        res
);

    localparam int PB     = POSITION_BITS;
    localparam int IB     = INTEGRAL_BITS;
    localparam int GW     = ptld_pkg::GAIN_W;
    localparam int CW     = ptld_pkg::CHUNK_W;
    localparam int TQ_W   = ptld_pkg::TQ_W;
    localparam int LIM_W  = ptld_pkg::LIM_W;
    localparam int ERR_W  = ((PB > ptld_pkg::TARGET_W) ? PB : ptld_pkg::TARGET_W) + 1;
    localparam int DIFF_W = PB + 1;
    localparam int MB_A   = (ERR_W > DIFF_W) ? ERR_W : DIFF_W;
    localparam int MB_W   = (MB_A > IB) ? MB_A : IB;
    localparam int CH     = (MB_W + CW - 1) / CW;
    localparam int B_W    = CH * CW;
    localparam int ACC_W  = GW + B_W;
    localparam int MC_W   = (CH > 1) ? $clog2(CH) : 1;
    localparam int STEP_W = ERR_W + ptld_pkg::TICK_W;
    localparam int SUM_W  = ((IB > STEP_W) ? IB : STEP_W) + 1;
    localparam int DN_W   = GW + PB;
    localparam int LN_W   = 2 * ptld_pkg::TORQUE_W + ptld_pkg::SPEED_W;
    localparam int LF_W   = LIM_W + GAIN_FRAC_BITS;
    localparam int DEN_W  = (LF_W > ptld_pkg::TICK_W) ? LF_W : ptld_pkg::TICK_W;
    localparam int DVD_W  = (DN_W > LN_W) ? DN_W : LN_W;
    localparam int CNT_W  = $clog2(DVD_W + 1);
    localparam int CAP_W  = (ACC_W > ptld_pkg::TERM_MAX_EXP + 1) ? ACC_W
                                                                 : ptld_pkg::TERM_MAX_EXP + 1;
    localparam logic [CAP_W-1:0] TERM_LIM = CAP_W'(1) << ptld_pkg::TERM_MAX_EXP;

    // Configuration and loop state
    ptld_pkg::seq_state_t state_reg, state_next;
    logic signed [GW-1:0]                      gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [ptld_pkg::TARGET_W-1:0]      target_reg;
    logic [ptld_pkg::TORQUE_W-1:0]             max_torque_reg;
    logic [ptld_pkg::SPEED_W-1:0]              max_speed_reg;
    logic signed [PB-1:0]                      last_pos_reg;
    logic signed [IB-1:0]                      integ_reg;

    // Working registers
    logic signed [PB-1:0]                      pos_reg;
    logic [ptld_pkg::TICK_W-1:0]               ticks_reg;
    logic signed [ERR_W-1:0]                   err_reg;
    logic [ptld_pkg::SPEED_W-1:0]              spdiff_reg;
    logic                                      hr_reg;
    logic                                      zi_reg;
    logic [GW-1:0]                             a_reg;
    logic [B_W-1:0]                            b_reg;
    logic [ACC_W-1:0]                          acc_reg;
    logic [MC_W-1:0]                           mcnt_reg;
    logic                                      term_neg_reg;
    logic signed [TQ_W-1:0]                    torque_reg;
    logic [LIM_W-1:0]                          lim_reg;
    logic [ptld_pkg::DUTY_W-1:0]               duty_reg;
    logic                                      cl_reg, nh_reg;

    // Combinational values
    logic signed [ERR_W-1:0]                   err_in;
    logic [ERR_W-1:0]                          err_abs_in;
    logic [ERR_W-1:0]                          err_abs;
    logic signed [ptld_pkg::SPEED_W:0]         spd_ext;
    logic [ptld_pkg::SPEED_W:0]                aspd;
    logic [GW-1:0]                             gp_abs, gi_abs, gd_abs;
    logic [IB-1:0]                             integ_abs;
    logic signed [DIFF_W-1:0]                  diff;
    logic [DIFF_W-1:0]                         diff_abs;
    logic [CW-1:0]                             chunk;
    logic [GW+CW-1:0]                          prod;
    logic [ACC_W-1:0]                          acc_step;
    logic                                      mul_last;
    logic signed [SUM_W-1:0]                   step_s, isum;
    logic signed [IB-1:0]                      isat;
    logic [CAP_W-1:0]                          acc_ext, term_mag;
    logic [TQ_W-1:0]                           add_mag;
    logic signed [TQ_W-1:0]                    torque_sum;
    logic [TQ_W-1:0]                           t_abs;
    logic [LF_W-1:0]                           lf, lf_hi;
    logic                                      over;
    logic [ptld_pkg::QUOT_BITS-1:0]            q;

    // Divider hookup
    logic                                      div_start;
    logic [CNT_W-1:0]                          div_steps;
    logic [DEN_W-1:0]                          div_rem_init;
    logic [DVD_W-1:0]                          div_dvd_init;
    logic [DEN_W-1:0]                          div_den;
    logic                                      div_done;
    logic [DVD_W-1:0]                          div_quot;

    ptld_div #(
        .DVD_W (DVD_W),
        .DEN_W (DEN_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .steps    (div_steps),
        .rem_init (div_rem_init),
        .dvd_init (div_dvd_init),
        .den      (div_den),
        .done     (div_done),
        .quot     (div_quot)
    );

    // Request-side arithmetic: error and speed headroom
    always_comb
    begin
        err_in     = ERR_W'(target_reg) - ERR_W'(cmd.position);
        err_abs_in = err_in[ERR_W-1] ? ERR_W'(-err_in) : ERR_W'(err_in);
        spd_ext    = (ptld_pkg::SPEED_W+1)'(cmd.motor_speed);
        aspd       = spd_ext[ptld_pkg::SPEED_W] ? (ptld_pkg::SPEED_W+1)'(-spd_ext)
                                                : (ptld_pkg::SPEED_W+1)'(spd_ext);
    end

    // Operand magnitudes
    always_comb
    begin
        err_abs   = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
        gp_abs    = gain_p_reg[GW-1] ? GW'(-gain_p_reg) : GW'(gain_p_reg);
        gi_abs    = gain_i_reg[GW-1] ? GW'(-gain_i_reg) : GW'(gain_i_reg);
        gd_abs    = gain_d_reg[GW-1] ? GW'(-gain_d_reg) : GW'(gain_d_reg);
        integ_abs = integ_reg[IB-1] ? IB'(-integ_reg) : IB'(integ_reg);
        diff      = DIFF_W'(pos_reg) - DIFF_W'(last_pos_reg);
        diff_abs  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    end

    // Shared multiplier: top chunk first, accumulate with a 16-bit shift
    always_comb
    begin
        chunk    = b_reg[B_W-1 -: CW];
        prod     = a_reg * chunk;
        acc_step = (acc_reg << CW) + ACC_W'(prod);
        mul_last = (mcnt_reg == MC_W'(CH - 1));
    end

    // Saturating integral update
    always_comb
    begin
        step_s = SUM_W'(acc_reg[STEP_W-2:0]);
        if (err_reg[ERR_W-1])
        begin
            step_s = -step_s;
        end
        isum = SUM_W'(integ_reg) + step_s;
        if (isum[SUM_W-1:IB-1] == '0 || isum[SUM_W-1:IB-1] == '1)
        begin
            isat = isum[IB-1:0];
        end
        else if (isum[SUM_W-1])
        begin
            isat = {1'b1, {(IB-1){1'b0}}};
        end
        else
        begin
            isat = {1'b0, {(IB-1){1'b1}}};
        end
    end

    // Term accumulation into torque, product terms capped at 2^60
    always_comb
    begin
        acc_ext  = CAP_W'(acc_reg);
        term_mag = (acc_ext > TERM_LIM) ? TERM_LIM : acc_ext;
        if (state_reg == ptld_pkg::ST_L_LOAD)
        begin
            add_mag = zi_reg ? '0 : TQ_W'(div_quot);
        end
        else
        begin
            add_mag = TQ_W'(term_mag);
        end
        torque_sum = term_neg_reg ? torque_reg - $signed(add_mag)
                                  : torque_reg + $signed(add_mag);
    end

    // Ratio checks against the scaled limit
    always_comb
    begin
        t_abs = torque_reg[TQ_W-1] ? TQ_W'(-torque_reg) : TQ_W'(torque_reg);
        lf    = LF_W'(lim_reg) << GAIN_FRAC_BITS;
        lf_hi = lf >> CW;
        over  = (t_abs > TQ_W'(lf_hi)) || ({t_abs[LF_W-CW-1:0], {CW{1'b0}}} >= lf);
        q     = div_quot[ptld_pkg::QUOT_BITS-1:0];
    end

    // Sequencer: next state and divider requests
    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_steps    = '0;
        div_rem_init = '0;
        div_dvd_init = '0;
        div_den      = '0;
        unique case (state_reg)
            ptld_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = (cmd.command == ptld_pkg::CMD_START) ? ptld_pkg::ST_DONE
                                                                      : ptld_pkg::ST_STEP_MUL;
                end
            end
            ptld_pkg::ST_STEP_MUL:
            begin
                if (mul_last)
                begin
                    state_next = ptld_pkg::ST_INTEG;
                end
            end
            ptld_pkg::ST_INTEG:
            begin
                state_next = ptld_pkg::ST_P_MUL;
            end
            ptld_pkg::ST_P_MUL:
            begin
                if (mul_last)
                begin
                    state_next = ptld_pkg::ST_I_LOAD;
                end
            end
            ptld_pkg::ST_I_LOAD:
            begin
                state_next = ptld_pkg::ST_I_MUL;
            end
            ptld_pkg::ST_I_MUL:
            begin
                if (mul_last)
                begin
                    state_next = ptld_pkg::ST_D_LOAD;
                end
            end
            ptld_pkg::ST_D_LOAD:
            begin
                state_next = ptld_pkg::ST_D_MUL;
            end
            ptld_pkg::ST_D_MUL:
            begin
                if (mul_last)
                begin
                    state_next = zi_reg ? ptld_pkg::ST_L_LOAD : ptld_pkg::ST_D_START;
                end
            end
            ptld_pkg::ST_D_START:
            begin
                div_start    = 1'b1;
                div_steps    = CNT_W'(DN_W);
                div_dvd_init = DVD_W'(acc_reg) << (DVD_W - DN_W);
                div_den      = DEN_W'(ticks_reg);
                state_next   = ptld_pkg::ST_D_WAIT;
            end
            ptld_pkg::ST_D_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ptld_pkg::ST_L_LOAD;
                end
            end
            ptld_pkg::ST_L_LOAD:
            begin
                state_next = ptld_pkg::ST_L_MUL;
            end
            ptld_pkg::ST_L_MUL:
            begin
                if (mul_last)
                begin
                    state_next = ptld_pkg::ST_L_START;
                end
            end
            ptld_pkg::ST_L_START:
            begin
                div_start    = 1'b1;
                div_steps    = CNT_W'(LN_W);
                div_dvd_init = DVD_W'({acc_reg[2*ptld_pkg::TORQUE_W-1:0], {CW{1'b0}}})
                               << (DVD_W - LN_W);
                div_den      = DEN_W'(max_speed_reg);
                state_next   = ptld_pkg::ST_L_WAIT;
            end
            ptld_pkg::ST_L_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ptld_pkg::ST_RATIO;
                end
            end
            ptld_pkg::ST_RATIO:
            begin
                if (lim_reg == '0 || over)
                begin
                    state_next = ptld_pkg::ST_DONE;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_steps    = CNT_W'(ptld_pkg::QUOT_BITS);
                    div_rem_init = DEN_W'({t_abs[LF_W-CW-1:0], {CW{1'b0}}});
                    div_den      = DEN_W'(lf);
                    state_next   = ptld_pkg::ST_Q_WAIT;
                end
            end
            ptld_pkg::ST_Q_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ptld_pkg::ST_DONE;
                end
            end
            ptld_pkg::ST_DONE:
            begin
                if (res.ready)
                begin
                    state_next = ptld_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptld_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold state, configuration, last position and integral
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ptld_pkg::ST_IDLE;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            target_reg     <= '0;
            max_torque_reg <= '1;
            max_speed_reg  <= '1;
            last_pos_reg   <= '0;
            integ_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ptld_pkg::CFG_GAIN_P:     gain_p_reg     <= cfg_data[GW-1:0];
                    ptld_pkg::CFG_GAIN_I:     gain_i_reg     <= cfg_data[GW-1:0];
                    ptld_pkg::CFG_GAIN_D:     gain_d_reg     <= cfg_data[GW-1:0];
                    ptld_pkg::CFG_TARGET:     target_reg     <= cfg_data[ptld_pkg::TARGET_W-1:0];
                    ptld_pkg::CFG_MAX_TORQUE: max_torque_reg <= cfg_data[ptld_pkg::TORQUE_W-1:0];
                    ptld_pkg::CFG_MAX_SPEED:  max_speed_reg  <= cfg_data[ptld_pkg::SPEED_W-1:0];
                    default:                  ;
                endcase
            end
            if (state_reg == ptld_pkg::ST_IDLE && cmd.valid
                && cmd.command == ptld_pkg::CMD_START)
            begin
                last_pos_reg <= cmd.position;
            end
            else if (state_reg == ptld_pkg::ST_D_LOAD)
            begin
                last_pos_reg <= pos_reg;
            end
            if (state_reg == ptld_pkg::ST_INTEG)
            begin
                integ_reg <= isat;
            end
        end
    end

    // Working datapath
    always_ff @(posedge clk)
    begin
        if (state_reg != ptld_pkg::ST_IDLE && state_reg != ptld_pkg::ST_DONE)
        begin
            mcnt_reg <= mcnt_reg + MC_W'(1);
            acc_reg  <= acc_step;
            b_reg    <= b_reg << CW;
        end
        unique case (state_reg)
            ptld_pkg::ST_IDLE:
            begin
                // Latch the request and load the error-times-ticks product
                pos_reg    <= cmd.position;
                ticks_reg  <= cmd.elapsed_ticks;
                err_reg    <= err_in;
                zi_reg     <= (cmd.elapsed_ticks == '0);
                hr_reg     <= ({1'b0, max_speed_reg} > aspd);
                spdiff_reg <= max_speed_reg - aspd[ptld_pkg::SPEED_W-1:0];
                a_reg      <= GW'(cmd.elapsed_ticks);
                b_reg      <= B_W'(err_abs_in);
                acc_reg    <= '0;
                mcnt_reg   <= '0;
                torque_reg <= '0;
                duty_reg   <= '0;
                cl_reg     <= 1'b0;
                nh_reg     <= 1'b0;
                if (cmd.command == ptld_pkg::CMD_START)
                begin
                    zi_reg <= 1'b0;
                end
            end
            ptld_pkg::ST_INTEG:
            begin
                a_reg        <= gp_abs;
                b_reg        <= B_W'(err_abs);
                acc_reg      <= '0;
                mcnt_reg     <= '0;
                term_neg_reg <= gain_p_reg[GW-1] ^ err_reg[ERR_W-1];
            end
            ptld_pkg::ST_I_LOAD:
            begin
                torque_reg   <= torque_sum;
                a_reg        <= gi_abs;
                b_reg        <= B_W'(integ_abs);
                acc_reg      <= '0;
                mcnt_reg     <= '0;
                term_neg_reg <= gain_i_reg[GW-1] ^ integ_reg[IB-1];
            end
            ptld_pkg::ST_D_LOAD:
            begin
                torque_reg   <= torque_sum;
                a_reg        <= gd_abs;
                b_reg        <= B_W'(diff_abs);
                acc_reg      <= '0;
                mcnt_reg     <= '0;
                term_neg_reg <= gain_d_reg[GW-1] ^ diff[DIFF_W-1];
            end
            ptld_pkg::ST_L_LOAD:
            begin
                torque_reg <= torque_sum;
                a_reg      <= GW'(max_torque_reg);
                b_reg      <= {spdiff_reg, {(B_W-CW){1'b0}}} >> (B_W - CW);
                acc_reg    <= '0;
                mcnt_reg   <= '0;
            end
            ptld_pkg::ST_L_WAIT:
            begin
                lim_reg <= hr_reg ? div_quot[LIM_W-1:0] : '0;
            end
            ptld_pkg::ST_RATIO:
            begin
                // Saturate by sign on zero limit or full scale
                if (lim_reg == '0)
                begin
                    nh_reg   <= 1'b1;
                    cl_reg   <= (t_abs != '0);
                    duty_reg <= (t_abs == '0) ? '0
                              : (torque_reg[TQ_W-1] ? -ptld_pkg::DUTY_FULL
                                                    : ptld_pkg::DUTY_FULL);
                end
                else if (over)
                begin
                    cl_reg   <= 1'b1;
                    duty_reg <= torque_reg[TQ_W-1] ? -ptld_pkg::DUTY_FULL
                                                   : ptld_pkg::DUTY_FULL;
                end
            end
            ptld_pkg::ST_Q_WAIT:
            begin
                duty_reg <= torque_reg[TQ_W-1] ? -ptld_pkg::DUTY_W'(q)
                                               : ptld_pkg::DUTY_W'(q);
            end
            default:
            begin
            end
        endcase
    end

    // Channel handshakes and result payload
    assign cmd.ready         = (state_reg == ptld_pkg::ST_IDLE);
    assign res.valid         = (state_reg == ptld_pkg::ST_DONE);
    assign res.duty          = duty_reg;
    assign res.clamped       = cl_reg;
    assign res.no_headroom   = nh_reg;
    assign res.zero_interval = zi_reg;

endmodule

@@ hw/rtl/ptld_div.sv @@
// ----------------------------------------------------------------------------
// ptld_div
// Bit-serial restoring divider, one quotient bit per cycle. The remainder
// can be preloaded so that fractional quotient bits can be produced.
// ----------------------------------------------------------------------------
module ptld_div #(
    parameter int DVD_W = 48,
    parameter int DEN_W = 44,
    parameter int CNT_W = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] steps,
    input  logic [DEN_W-1:0] rem_init,
    input  logic [DVD_W-1:0] dvd_init,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [DVD_W-1:0] quot
);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DVD_W-1:0] quot_reg;

    logic [DEN_W:0]   rem_sh;
    logic             fits;
    logic [DEN_W:0]   rem_sub;

    // Shift in the next dividend bit and trial-subtract
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
        fits    = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    // Step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= steps;
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Remainder, dividend and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= rem_init;
            dvd_reg  <= dvd_init;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
            quot_reg <= {quot_reg[DVD_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ dv/tb_pid_torque_limited_duty.sv @@
// ----------------------------------------------------------------------------
// tb_pid_torque_limited_duty
// Drives start and update requests with random gaps, predicts each duty from
// a model of the loop kept in the bench, and compares the results in order.
// ----------------------------------------------------------------------------
module tb_pid_torque_limited_duty;

    typedef struct packed {
        logic        command;
        logic [15:0] position;
        logic [15:0] motor_speed;
        logic [15:0] elapsed_ticks;
    } request_t;

    typedef struct packed {
        logic [15:0] duty;
        logic        clamped;
        logic        no_headroom;
        logic        zero_interval;
    } duty_result_t;

    localparam longint TERM_LIMIT = longint'(1) << 60;
    localparam longint INTEG_HI   = (longint'(1) << 47) - 1;
    localparam longint INTEG_LO   = -(longint'(1) << 47);

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ptld_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ptld_pkg::CFG_DATA_W-1:0] cfg_data;

    ptld_cmd_if cmd ();
    ptld_res_if res ();

    pid_torque_limited_duty DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cmd(cmd.sink), .res(res.source)
    );

    // Predictor state
    logic signed [23:0] kp, ki, kd;
    logic signed [15:0] setpoint;
    logic [15:0] torque_cap, speed_cap;
    longint prev_pos;
    longint integ_acc;

    request_t     pending_q[$];
    duty_result_t expected_q[$];
    int  mismatches;
    int  results_seen;
    int  updates_sent;
    int  hold_cycles;
    bit  stimulus_done;
    bit  in_taken;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200000000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint clamp_product(longint a, longint b);
        longint ua, ub;
        longint p;
        bit neg;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        neg = (a < 0) != (b < 0);
        if (ua != 0 && ub > TERM_LIMIT / ua)
            p = TERM_LIMIT;
        else
            p = ua * ub;
        if (p > TERM_LIMIT)
            p = TERM_LIMIT;
        return neg ? -p : p;
    endfunction

    // Work out the duty for one request and advance the loop state
    function automatic duty_result_t compute_duty(request_t rq);
        duty_result_t r;
        longint pos, spd, ticks, err, stp, deriv, torque;
        longint unsigned t, aspd, lim, lf, rem, q;
        longint d;
        r = '0;
        pos = longint'($signed(rq.position));
        if (rq.command == ptld_pkg::CMD_START)
        begin
            prev_pos = pos;
            return r;
        end
        spd = longint'($signed(rq.motor_speed));
        ticks = longint'(rq.elapsed_ticks);
        err = longint'(setpoint) - pos;
        r.zero_interval = (ticks == 0);
        stp = err * ticks;
        if (stp > 0 && integ_acc > INTEG_HI - stp)
            integ_acc = INTEG_HI;
        else if (stp < 0 && integ_acc < INTEG_LO - stp)
            integ_acc = INTEG_LO;
        else
            integ_acc = integ_acc + stp;
        deriv = (ticks == 0) ? 0 : (longint'(kd) * (pos - prev_pos)) / ticks;
        if (deriv > TERM_LIMIT) deriv = TERM_LIMIT;
        if (deriv < -TERM_LIMIT) deriv = -TERM_LIMIT;
        prev_pos = pos;
        torque = clamp_product(longint'(kp), err) + clamp_product(longint'(ki), integ_acc)
                 + deriv;
        t = (torque < 0) ? -torque : torque;
        aspd = (spd < 0) ? -spd : spd;
        lim = 0;
        if (aspd < speed_cap)
            lim = ((longint'(torque_cap) * (speed_cap - aspd)) << 16) / speed_cap;
        d = 0;
        if (lim == 0)
        begin
            r.no_headroom = 1'b1;
            if (t != 0)
            begin
                r.clamped = 1'b1;
                d = 32767;
            end
        end
        else
        begin
            lf = lim << ptld_pkg::GAIN_FRAC_BITS;
            if (t > (lf >> 16) || (t << 16) >= lf)
            begin
                r.clamped = 1'b1;
                d = 32767;
            end
            else
            begin
                rem = t << 16;
                q = 0;
                for (int i = 0; i < 15; i++)
                begin
                    rem = rem << 1;
                    q = q << 1;
                    if (rem >= lf)
                    begin
                        rem = rem - lf;
                        q = q | 1;
                    end
                end
                d = q;
            end
        end
        if (torque < 0)
            d = -d;
        r.duty = d[15:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        mismatches++;
        $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
    endtask

    // Write one register at a falling edge and mirror it in the predictor
    task automatic write_reg(ptld_pkg::cfg_index_t idx, logic [23:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ptld_pkg::CFG_GAIN_P:     kp = value;
            ptld_pkg::CFG_GAIN_I:     ki = value;
            ptld_pkg::CFG_GAIN_D:     kd = value;
            ptld_pkg::CFG_TARGET:     setpoint = value[15:0];
            ptld_pkg::CFG_MAX_TORQUE: torque_cap = value[15:0];
            ptld_pkg::CFG_MAX_SPEED:  speed_cap = value[15:0];
            default: ;
        endcase
    endtask

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Driver: offer queued requests, with random gaps between them
    int send_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
            send_gap = 0;
        end
        else if (cmd.valid && !in_taken)
        begin
            // hold the offered request until it is taken
        end
        else if (send_gap > 0)
        begin
            cmd.valid <= 1'b0;
            send_gap--;
        end
        else if (pending_q.size() > 0)
        begin
            request_t rq;
            rq = pending_q.pop_front();
            cmd.valid <= 1'b1;
            cmd.command <= rq.command;
            cmd.position <= rq.position;
            cmd.motor_speed <= rq.motor_speed;
            cmd.elapsed_ticks <= rq.elapsed_ticks;
            send_gap = gap_len();
        end
        else
            cmd.valid <= 1'b0;
        in_taken = 1'b0;
    end

    // Receiver back-pressure; a long hold can be forced from the stimulus
    always @(negedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles--;
            res.ready <= 1'b0;
        end
        else
            res.ready <= (gap_len() == 0) || ($urandom_range(0, 1) == 1);
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        if (rst_n && cmd.valid && cmd.ready)
        begin
            request_t rq;
            rq = {cmd.command, cmd.position, cmd.motor_speed, cmd.elapsed_ticks};
            expected_q.push_back(compute_duty(rq));
            in_taken = 1'b1;
        end
        if (rst_n && res.valid && res.ready)
        begin
            duty_result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("unexpected result %0d", results_seen);
            end
            else
            begin
                want = expected_q.pop_front();
                if (res.duty !== want.duty)
                    report_mismatch("duty", res.duty, want.duty);
                if (res.clamped !== want.clamped)
                    report_mismatch("clamped", res.clamped, want.clamped);
                if (res.no_headroom !== want.no_headroom)
                    report_mismatch("no_headroom", res.no_headroom, want.no_headroom);
                if (res.zero_interval !== want.zero_interval)
                    report_mismatch("zero_interval", res.zero_interval, want.zero_interval);
            end
        end
    end

    function automatic request_t make_req(logic c, logic [15:0] p, logic [15:0] s,
                                          logic [15:0] t);
        request_t rq;
        rq.command = c;
        rq.position = p;
        rq.motor_speed = s;
        rq.elapsed_ticks = t;
        return rq;
    endfunction

    function automatic logic [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // Wait until every queued request has been sent and answered
    task automatic drain();
        do
            @(posedge clk);
        while (pending_q.size() != 0 || cmd.valid || expected_q.size() != 0);
        repeat (200) @(negedge clk);
    endtask

    function automatic logic [23:0] rand_gain();
        case ($urandom_range(0, 4))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'($urandom_range(0, 16384)) - 24'd8192;
            default: return 24'($urandom);
        endcase
    endfunction

    // Stimulus
    initial
    begin
        mismatches = 0;
        results_seen = 0;
        updates_sent = 0;
        hold_cycles = 0;
        stimulus_done = 0;
        in_taken = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd.valid = 1'b0;
        cmd.command = ptld_pkg::CMD_START;
        cmd.position = '0;
        cmd.motor_speed = '0;
        cmd.elapsed_ticks = '0;
        res.ready = 1'b0;
        kp = 0; ki = 0; kd = 0; setpoint = 0;
        torque_cap = 16'hFFFF; speed_cap = 16'hFFFF;
        prev_pos = 0; integ_acc = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, then moderate gains
        pending_q.push_back(make_req(ptld_pkg::CMD_UPDATE, 16'd100, 16'd0, 16'd1));
        drain();
        write_reg(ptld_pkg::CFG_GAIN_P, 24'h001000);
        write_reg(ptld_pkg::CFG_GAIN_I, 24'h000010);
        write_reg(ptld_pkg::CFG_GAIN_D, 24'h000800);
        write_reg(ptld_pkg::CFG_TARGET, 24'h000000);
        write_reg(ptld_pkg::CFG_MAX_TORQUE, 24'd1000);
        write_reg(ptld_pkg::CFG_MAX_SPEED, 24'd2000);
        pending_q.push_back(make_req(ptld_pkg::CMD_START, 16'h8000, 16'h0, 16'h0));
        pending_q.push_back(make_req(ptld_pkg::CMD_UPDATE, 16'h7FFF, 16'h0, 16'hFFFF));
        pending_q.push_back(make_req(ptld_pkg::CMD_UPDATE, 16'h8000, 16'h8000, 16'h0001));
        pending_q.push_back(make_req(ptld_pkg::CMD_UPDATE, 16'd5, 16'd100, 16'd0));
        pending_q.push_back(make_req(ptld_pkg::CMD_UPDATE, 16'd0, 16'd2000, 16'd3));
        pending_q.push_back(make_req(ptld_pkg::CMD_UPDATE, 16'd0, 16'd1999, 16'd3));
        pending_q.push_back(make_req(ptld_pkg::CMD_UPDATE, 16'd1, 16'h7FFF, 16'd1));
        pending_q.push_back(make_req(ptld_pkg::CMD_UPDATE, 16'd0, 16'd0, 16'd1));
        pending_q.push_back(make_req(ptld_pkg::CMD_START, 16'd0, 16'h7FFF, 16'hFFFF));
        pending_q.push_back(make_req(ptld_pkg::CMD_UPDATE, 16'hFFFF, 16'hFFFF, 16'd2));
        drain();
        // Extreme gains drive the integral and terms into saturation
        write_reg(ptld_pkg::CFG_GAIN_P, 24'h7FFFFF);
        write_reg(ptld_pkg::CFG_GAIN_I, 24'h800000);
        write_reg(ptld_pkg::CFG_GAIN_D, 24'h7FFFFF);
        write_reg(ptld_pkg::CFG_TARGET, 24'h007FFF);
        write_reg(ptld_pkg::CFG_MAX_TORQUE, 24'd0);
        write_reg(ptld_pkg::CFG_MAX_SPEED, 24'd1);
        repeat (6) pending_q.push_back(make_req(ptld_pkg::CMD_UPDATE, 16'h8000, 16'd0,
                                                16'hFFFF));
        pending_q.push_back(make_req(ptld_pkg::CMD_UPDATE, 16'h7FFF, 16'd0, 16'd1));
        drain();
        write_reg(ptld_pkg::CFG_MAX_TORQUE, 24'hFFFF);
        write_reg(ptld_pkg::CFG_MAX_SPEED, 24'hFFFF);
        write_reg(ptld_pkg::CFG_TARGET, 24'h008000);
        repeat (4) pending_q.push_back(make_req(ptld_pkg::CMD_UPDATE, 16'h7FFF, 16'h8000,
                                                16'hFFFF));
        // Hold the receiver for a long stretch while requests keep coming
        hold_cycles = 2000;
        drain();

        // Random phases with fresh settings each time
        for (int ph = 0; ph < 14; ph++)
        begin
            if (ph % 3 == 0)
            begin
                write_reg(ptld_pkg::CFG_GAIN_P, rand_gain());
                write_reg(ptld_pkg::CFG_GAIN_I, rand_gain());
                write_reg(ptld_pkg::CFG_GAIN_D, rand_gain());
            end
            else
            begin
                write_reg(ptld_pkg::CFG_GAIN_P, 24'($urandom_range(0, 32768)) - 24'd16384);
                write_reg(ptld_pkg::CFG_GAIN_I, 24'($urandom_range(0, 64)) - 24'd32);
                write_reg(ptld_pkg::CFG_GAIN_D, 24'($urandom_range(0, 8192)) - 24'd4096);
            end
            write_reg(ptld_pkg::CFG_TARGET, 24'(rand_field()));
            write_reg(ptld_pkg::CFG_MAX_TORQUE,
                      (ph == 5) ? 24'd0 : 24'($urandom_range(0, 65535)));
            write_reg(ptld_pkg::CFG_MAX_SPEED,
                      (ph == 7) ? 24'd1 : 24'($urandom_range(1, 65535)));
            pending_q.push_back(make_req(ptld_pkg::CMD_START, rand_field(), rand_field(),
                                         rand_field()));
            for (int n = 0; n < 100; n++)
            begin
                logic [15:0] tk;
                tk = ($urandom_range(0, 9) == 0) ? 16'd0 :
                     ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 20));
                pending_q.push_back(make_req(($urandom_range(0, 9) == 0) ? ptld_pkg::CMD_START
                                                                        : ptld_pkg::CMD_UPDATE,
                                             rand_field(), rand_field(), tk));
                updates_sent++;
            end
            if (ph == 4)
                hold_cycles = 1500;
            // Pause the sender until every result has arrived
            drain();
        end

        stimulus_done = 1;
        $display("covered %0d random requests over 14 settings, %0d results checked",
                 updates_sent, results_seen);
        $display("saturation, zero tick, no headroom and full scale cases were driven");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
